// ===== hw/rtl/ppg_pkg.sv =====
package ppg_pkg;

  localparam int SIG_W  = 28;
  localparam int RATE_W = 16;
  localparam int INTV_W = 24;
  localparam int NUM_W  = 34;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 24;

  localparam logic [15:0]       DECAY_FAST = 16'd63570;
  localparam logic [15:0]       DECAY_SLOW = 16'd65208;
  localparam logic [NUM_W-1:0]  RATE_NUM   = 34'd15360000000;
  localparam logic [31:0]       TIMEOUT_US = 32'd5000000;
  localparam logic [31:0]       DIV10_MAG  = 32'hCCCCCCCD;

  localparam logic [CIDX_W-1:0] REG_HP_COEFF  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_LP_ALPHA  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_WARMUP    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_CONTACT   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_MIN_INTV  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_MAX_INTV  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_ENV_FLOOR = 3'd6;
  localparam logic [CIDX_W-1:0] REG_ENV_CLIP  = 3'd7;

  typedef struct packed {
    logic [15:0]       hp_coeff;
    logic [15:0]       lp_alpha;
    logic [15:0]       warmup;
    logic [17:0]       contact_step;
    logic [INTV_W-1:0] min_intv;
    logic [INTV_W-1:0] max_intv;
    logic [11:0]       env_floor;
    logic [11:0]       env_clip;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HP,
    ST_LP,
    ST_ENV,
    ST_THR,
    ST_DIV,
    ST_RATE,
    ST_OUT
  } state_t;

endpackage

// ===== hw/rtl/ppg_queue.sv =====
module ppg_queue #(
  parameter int W = 84
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] slot0_r, slot1_r;
  logic [1:0]   cnt_r;
  logic         push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0_r <= (cnt_r == 2'd2) ? slot1_r : in_data;
      if (push && cnt_r == 2'd2) begin
        slot1_r <= in_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= in_data;
      end else begin
        slot1_r <= in_data;
      end
    end
  end

endmodule

// ===== hw/rtl/ppg_back.sv =====
module ppg_back #(
  parameter int S = 18,
  parameter int F = 8,
  parameter int T = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ppg_pkg::cfg_t               cfg,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [S-1:0]                req_ir,
  input  logic [17:0]                 req_red,
  input  logic [T-1:0]                req_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [S-1:0]                out_ir_raw,
  output logic signed [ppg_pkg::SIG_W-1:0] out_filtered,
  output logic [17:0]                 out_red_raw,
  output logic [ppg_pkg::RATE_W-1:0]  out_heart_rate,
  output logic                        out_beat,
  output logic                        out_detecting
);

  localparam int SIG_W = ppg_pkg::SIG_W;
  localparam int NUM_W = ppg_pkg::NUM_W;
  localparam int IW    = ppg_pkg::INTV_W;
  localparam int DW    = S + 1;
  localparam int MW    = ((SIG_W > DW + F) ? SIG_W : DW + F) + 1;
  localparam int PW    = MW + 17;
  localparam int ENV_W = 12 + F;
  localparam int AW    = (SIG_W > ENV_W) ? SIG_W : ENV_W;
  localparam int CW    = ((SIG_W + 7 > ENV_W + 4) ? SIG_W + 7 : ENV_W + 4) + 1;
  localparam int SW    = (DW > 18) ? DW : 18;
  localparam logic signed [PW-1:0] HALF  = PW'(32768);
  localparam logic signed [PW-1:0] SMAX  = PW'((64'sd1 <<< (SIG_W - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SMIN  = -PW'(64'sd1 <<< (SIG_W - 1));

  ppg_pkg::state_t state_r, state_nxt;

  logic                    primed_r, above_r, bseen_r, det_r, beat_r, out_valid_r;
  logic [S-1:0]            prev_r, ir_r;
  logic [17:0]             red_r;
  logic [T-1:0]            now_r, last_r;
  logic signed [SIG_W-1:0] hp_r, lp_r;
  logic [ENV_W-1:0]        env_r;
  logic [15:0]             seen_r;
  logic [15:0]             rate_r;
  logic signed [MW-1:0]    sum_r;
  logic [NUM_W-1:0]        num_r, quo_r;
  logic [IW-1:0]           rem_r, dvs_r;
  logic [5:0]              cnt_r;

  logic                    out_free, go_div;
  logic signed [16:0]      mul_a;
  logic signed [MW-1:0]    mul_b;
  logic signed [PW-1:0]    mul_p, rnd_t, rnd, lsum;
  logic [S-1:0]            prev_eff;
  logic signed [DW-1:0]    diff;
  logic [DW-1:0]           absd;
  logic [SIG_W-1:0]        absy;
  logic [ENV_W-1:0]        clip, env_new;
  logic [AW+3:0]           ax10, ex3;
  logic [ENV_W+15:0]       dec_p;
  logic signed [CW-1:0]    lp20, lp100, env7;
  logic [T-1:0]            rr;
  logic                    beat_c, in_rng;
  logic [IW:0]             rem_w;
  logic [15:0]             inst;
  logic [19:0]             mix;
  logic [51:0]             mix_p;

  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppg_pkg::ST_IDLE: if (req_valid) state_nxt = ppg_pkg::ST_HP;
      ppg_pkg::ST_HP:   state_nxt = ppg_pkg::ST_LP;
      ppg_pkg::ST_LP:   state_nxt = ppg_pkg::ST_ENV;
      ppg_pkg::ST_ENV:  state_nxt = (seen_r >= cfg.warmup) ? ppg_pkg::ST_THR : ppg_pkg::ST_OUT;
      ppg_pkg::ST_THR:  state_nxt = go_div ? ppg_pkg::ST_DIV : ppg_pkg::ST_OUT;
      ppg_pkg::ST_DIV:  if (cnt_r == 6'd0) state_nxt = ppg_pkg::ST_RATE;
      ppg_pkg::ST_RATE: state_nxt = ppg_pkg::ST_OUT;
      ppg_pkg::ST_OUT:  if (out_free) state_nxt = ppg_pkg::ST_IDLE;
      default:          state_nxt = ppg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    mul_a     = {1'b0, cfg.hp_coeff};
    mul_b     = sum_r;
    case (state_r)
      ppg_pkg::ST_IDLE: req_ready = 1'b1;
      ppg_pkg::ST_LP: begin
        mul_a = {1'b0, cfg.lp_alpha};
        mul_b = MW'(hp_r) - MW'(lp_r);
      end
      default: ;
    endcase
  end

  // shared multiplier with round-half-up to Q.8
  assign mul_p = PW'(mul_a) * PW'(mul_b);
  assign rnd_t = mul_p + HALF;
  assign rnd   = rnd_t >>> 16;
  assign lsum  = PW'(lp_r) + rnd;

  assign prev_eff = primed_r ? prev_r : req_ir;
  assign diff     = $signed({1'b0, req_ir}) - $signed({1'b0, prev_eff});
  assign absd     = diff[DW-1] ? DW'(-diff) : DW'(diff);

  assign absy    = lp_r[SIG_W-1] ? SIG_W'(-lp_r) : SIG_W'(lp_r);
  assign clip    = {cfg.env_clip, {F{1'b0}}};
  assign ax10    = (AW+4)'(absy) * (AW+4)'(10);
  assign ex3     = (AW+4)'(env_r) * (AW+4)'(3);
  assign dec_p   = (ENV_W+16)'(env_r) *
                   (ENV_W+16)'((ax10 < ex3) ? ppg_pkg::DECAY_FAST : ppg_pkg::DECAY_SLOW);
  assign env_new = (AW'(absy) > AW'(env_r)) ?
                   ((AW'(absy) < AW'(clip)) ? ENV_W'(absy) : clip) : dec_p[ENV_W+15:16];

  assign lp20   = CW'(lp_r) * CW'(20);
  assign lp100  = CW'(lp_r) * CW'(100);
  assign env7   = $signed(CW'(env_r)) * CW'(7);
  assign beat_c = !above_r && (lp20 > env7) && (env_r > {cfg.env_floor, {F{1'b0}}});
  assign rr     = now_r - last_r;
  assign in_rng = (rr >= T'(cfg.min_intv)) && (rr <= T'(cfg.max_intv));
  assign go_div = beat_c && bseen_r && in_rng;

  assign rem_w = {rem_r, num_r[NUM_W-1]};
  assign inst  = (|quo_r[NUM_W-1:16]) ? 16'hFFFF : quo_r[15:0];
  assign mix   = 20'(rate_r) * 20'd7 + 20'(inst) * 20'd3 + 20'd5;
  assign mix_p = 52'(mix) * 52'(ppg_pkg::DIV10_MAG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppg_pkg::ST_IDLE;
      primed_r    <= 1'b0;
      above_r     <= 1'b0;
      bseen_r     <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      hp_r        <= '0;
      lp_r        <= '0;
      env_r       <= '0;
      seen_r      <= '0;
      rate_r      <= '0;
      last_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && state_r != ppg_pkg::ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ppg_pkg::ST_IDLE: begin
          if (req_valid) begin
            ir_r     <= req_ir;
            red_r    <= req_red;
            now_r    <= req_time;
            prev_r   <= req_ir;
            primed_r <= !(SW'(absd) > SW'(cfg.contact_step));
            sum_r    <= (primed_r ? MW'(hp_r) : MW'(0)) + (MW'(diff) <<< F);
            beat_r   <= 1'b0;
            if (!primed_r) begin
              lp_r    <= '0;
              env_r   <= '0;
              seen_r  <= '0;
              rate_r  <= '0;
              bseen_r <= 1'b0;
              last_r  <= '0;
            end
          end
        end
        ppg_pkg::ST_HP: begin
          hp_r <= (rnd > SMAX) ? SIG_W'(SMAX) : ((rnd < SMIN) ? SIG_W'(SMIN) : SIG_W'(rnd));
        end
        ppg_pkg::ST_LP: begin
          lp_r <= (lsum > SMAX) ? SIG_W'(SMAX) : ((lsum < SMIN) ? SIG_W'(SMIN) : SIG_W'(lsum));
          if (seen_r != 16'hFFFF) begin
            seen_r <= seen_r + 16'd1;
          end
        end
        ppg_pkg::ST_ENV: begin
          det_r <= (seen_r >= cfg.warmup);
          if (seen_r >= cfg.warmup) begin
            env_r <= env_new;
          end
        end
        ppg_pkg::ST_THR: begin
          if (beat_c) begin
            above_r <= 1'b1;
            beat_r  <= 1'b1;
            last_r  <= now_r;
            bseen_r <= 1'b1;
          end else if (above_r && lp100 < env7) begin
            above_r <= 1'b0;
          end
          num_r <= ppg_pkg::RATE_NUM + NUM_W'(rr[IW-1:1]);
          dvs_r <= rr[IW-1:0];
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= 6'(NUM_W - 1);
        end
        ppg_pkg::ST_DIV: begin
          num_r <= {num_r[NUM_W-2:0], 1'b0};
          cnt_r <= cnt_r - 6'd1;
          if (rem_w >= {1'b0, dvs_r}) begin
            rem_r <= IW'(rem_w - {1'b0, dvs_r});
            quo_r <= {quo_r[NUM_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_w[IW-1:0];
            quo_r <= {quo_r[NUM_W-2:0], 1'b0};
          end
        end
        ppg_pkg::ST_RATE: begin
          rate_r <= (rate_r == 16'd0) ? inst : mix_p[50:35];
        end
        ppg_pkg::ST_OUT: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_ir_raw     <= ir_r;
            out_filtered   <= lp_r;
            out_red_raw    <= red_r;
            out_beat       <= det_r && beat_r;
            out_detecting  <= det_r;
            out_heart_rate <= '0;
            if (det_r) begin
              if (bseen_r && rr > T'(ppg_pkg::TIMEOUT_US)) begin
                rate_r <= '0;
              end else begin
                out_heart_rate <= rate_r;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ppg_heart_rate_detector.sv =====
// PPG heart-rate detector.
// in_*  : one request per optical sample (ir, red, timestamp in us), valid/ready.
// out_* : one result per request in order: echoed samples, band-passed IR (Q19.8),
//         smoothed rate (Q8.8 bpm), beat and detecting flags, valid/ready.
// cfg_* : register writes (index, data), always ready; write only while idle.
// A two-entry input queue takes requests while the back end works on an earlier one.
// Each request steps through the HP, LP and ENV states, then THR once detecting, and
// the radix-2 divider and RATE when a beat interval is converted to a rate, then OUT;
// it may also wait behind earlier requests. The sequencer takes a new sample only once
// it has finished the last one.
// A stalled receiver holds the output register; the back end waits with its next
// result and the queue fills, then in_ready drops.
// Reset (synchronous, rst_n low) loads default registers and clears filter state,
// the queue and the output register; the first sample after reset primes the filters.
module ppg_heart_rate_detector #(
  parameter int SAMPLE_BITS = 18,
  parameter int FRAC_BITS   = 8,
  parameter int TIME_BITS   = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             in_ir_sample,
  input  logic [17:0]                        in_red_sample,
  input  logic [TIME_BITS-1:0]               in_time_us,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [SAMPLE_BITS-1:0]             out_ir_raw,
  output logic signed [ppg_pkg::SIG_W-1:0]   out_filtered,
  output logic [17:0]                        out_red_raw,
  output logic [ppg_pkg::RATE_W-1:0]         out_heart_rate,
  output logic                               out_beat,
  output logic                               out_detecting,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppg_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [ppg_pkg::CDAT_W-1:0]         cfg_data
);

  localparam int QW = SAMPLE_BITS + 18 + TIME_BITS;

  ppg_pkg::cfg_t          cfg_r;
  logic                   q_valid, q_ready;
  logic [QW-1:0]          q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hp_coeff     <= 16'd62915;
      cfg_r.lp_alpha     <= 16'd14418;
      cfg_r.warmup       <= 16'd300;
      cfg_r.contact_step <= 18'd20000;
      cfg_r.min_intv     <= 24'd333000;
      cfg_r.max_intv     <= 24'd2000000;
      cfg_r.env_floor    <= 12'd80;
      cfg_r.env_clip     <= 12'd3000;
    end else if (cfg_valid) begin
      case (cfg_index)
        ppg_pkg::REG_HP_COEFF:  cfg_r.hp_coeff     <= cfg_data[15:0];
        ppg_pkg::REG_LP_ALPHA:  cfg_r.lp_alpha     <= cfg_data[15:0];
        ppg_pkg::REG_WARMUP:    cfg_r.warmup       <= cfg_data[15:0];
        ppg_pkg::REG_CONTACT:   cfg_r.contact_step <= cfg_data[17:0];
        ppg_pkg::REG_MIN_INTV:  cfg_r.min_intv     <= cfg_data;
        ppg_pkg::REG_MAX_INTV:  cfg_r.max_intv     <= cfg_data;
        ppg_pkg::REG_ENV_FLOOR: cfg_r.env_floor    <= cfg_data[11:0];
        ppg_pkg::REG_ENV_CLIP:  cfg_r.env_clip     <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  ppg_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   ({in_ir_sample, in_red_sample, in_time_us}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  ppg_back #(.S(SAMPLE_BITS), .F(FRAC_BITS), .T(TIME_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .req_valid      (q_valid),
    .req_ready      (q_ready),
    .req_ir         (q_data[QW-1:18+TIME_BITS]),
    .req_red        (q_data[17+TIME_BITS:TIME_BITS]),
    .req_time       (q_data[TIME_BITS-1:0]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ir_raw     (out_ir_raw),
    .out_filtered   (out_filtered),
    .out_red_raw    (out_red_raw),
    .out_heart_rate (out_heart_rate),
    .out_beat       (out_beat),
    .out_detecting  (out_detecting)
  );

  a_beat_needs_detect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_beat || out_detecting))
    else $error("beat reported outside detection");

  a_rate_zero_warmup: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_detecting) |-> (out_heart_rate == '0))
    else $error("rate reported during warmup");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

endmodule
